FILE: design/cale_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cale_pkg
// Shared types, character codes and helpers for the call argument lexer.
// ----------------------------------------------------------------------------
package cale_pkg;

  // Longest string literal, in bytes
  localparam logic [9:0] MAX_STRING_CHARS = 10'd1013;

  // Token queue between lexer and output side
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Character codes
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_F   = 8'h46;
  localparam logic [7:0] CH_UP_X   = 8'h58;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LO_A   = 8'h61;
  localparam logic [7:0] CH_LO_F   = 8'h66;
  localparam logic [7:0] CH_LO_N   = 8'h6E;
  localparam logic [7:0] CH_LO_R   = 8'h72;
  localparam logic [7:0] CH_LO_X   = 8'h78;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;

  // Lexer modes
  typedef enum logic [3:0] {
    M_SEEK      = 4'd0,
    M_ITEM      = 4'd1,
    M_NEG       = 4'd2,
    M_DEC       = 4'd3,
    M_HEX       = 4'd4,
    M_CHR       = 4'd5,
    M_CHR_ESC   = 4'd6,
    M_CHR_CLOSE = 4'd7,
    M_AFTER     = 4'd8,
    M_STR       = 4'd9,
    M_STR_ESC   = 4'd10,
    M_DRAIN     = 4'd11
  } mode_t;

  // Token kinds
  typedef enum logic [2:0] {
    K_INT   = 3'd0,
    K_CHAR  = 3'd1,
    K_SBYTE = 3'd2,
    K_SEND  = 3'd3,
    K_LEND  = 3'd4,
    K_ERR   = 3'd5
  } kind_t;

  // Error codes
  typedef enum logic [3:0] {
    E_NONE       = 4'd0,
    E_NO_PAREN   = 4'd1,
    E_BAD_CHAR   = 4'd2,
    E_X_MISPLACE = 4'd3,
    E_BAD_HEX    = 4'd4,
    E_EARLY_END  = 4'd5,
    E_CHR_OPEN   = 4'd6,
    E_CHR_EMPTY  = 4'd7,
    E_STR_LONG   = 4'd8
  } err_t;

  // One output token
  typedef struct packed {
    kind_t       kind;
    logic [31:0] value;
    err_t        code;
    logic        last;
  } tok_t;

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= CH_ZERO) && (b <= CH_NINE);
  endfunction

  function automatic logic is_hex(input logic [7:0] b);
    return is_digit(b) || ((b >= CH_UP_A) && (b <= CH_UP_F)) ||
           ((b >= CH_LO_A) && (b <= CH_LO_F));
  endfunction

  function automatic logic [7:0] escape_value(input logic [7:0] b);
    logic [7:0] v;
    case (b)
      CH_LO_N: v = CH_LF;
      CH_LO_R: v = CH_CR;
      default: v = b;
    endcase
    return v;
  endfunction

  function automatic tok_t mk_tok(input kind_t k, input logic [31:0] v,
                                  input err_t c, input logic l);
    tok_t t;
    t.kind  = k;
    t.value = v;
    t.code  = c;
    t.last  = l;
    return t;
  endfunction

endpackage
`default_nettype wire

FILE: design/cale_lexer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cale_lexer
// Front end: takes one line byte per transfer, updates the lexer state and
// produces zero, one or two tokens for the queue.
// ----------------------------------------------------------------------------
module cale_lexer
  import cale_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       byte_valid,
  input  wire logic [7:0] line_byte,
  output tok_t            tok0,
  output tok_t            tok1,
  output logic [1:0]      tok_count
);

  mode_t       mode, mode_next;
  logic [31:0] acc, acc_next;
  logic        neg, neg_next;
  logic [9:0]  slen, slen_next;
  logic        hsp, hsp_next;

  logic [7:0]  b;
  logic [3:0]  dig;
  logic [3:0]  hdig;
  logic [31:0] int_val;
  logic [7:0]  esc;
  logic        do_item;
  mode_t       close_mode;

  assign b          = line_byte;
  assign dig        = b[3:0];
  assign hdig       = (b >= CH_UP_A) ? (b[3:0] + 4'd9) : b[3:0];
  assign int_val    = neg ? (32'd0 - acc) : acc;
  assign esc        = escape_value(b);
  assign close_mode = (b == CH_NUL) ? M_SEEK : M_DRAIN;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= M_SEEK;
      acc  <= '0;
      neg  <= 1'b0;
      slen <= '0;
      hsp  <= 1'b0;
    end else if (byte_valid) begin
      mode <= mode_next;
      acc  <= acc_next;
      neg  <= neg_next;
      slen <= slen_next;
      hsp  <= hsp_next;
    end
  end

  // Next state and token generation
  always_comb begin
    mode_next = mode;
    acc_next  = acc;
    neg_next  = neg;
    slen_next = slen;
    hsp_next  = hsp;
    tok0      = '0;
    tok1      = '0;
    tok_count = 2'd0;
    do_item   = 1'b0;

    case (mode)
      M_SEEK: begin
        if (b == CH_NUL) begin
          tok0      = mk_tok(K_ERR, 32'd0, E_NO_PAREN, 1'b1);
          tok_count = 2'd1;
          mode_next = M_SEEK;
        end else if (b == CH_LPAREN) begin
          mode_next = M_ITEM;
        end
      end
      M_ITEM: do_item = 1'b1;
      M_NEG: begin
        if (is_digit(b)) begin
          acc_next  = {28'd0, dig};
          neg_next  = 1'b1;
          hsp_next  = 1'b0;
          mode_next = M_DEC;
        end else begin
          do_item = 1'b1;
        end
      end
      M_DEC: begin
        if (is_digit(b)) begin
          acc_next = {acc[28:0], 3'b000} + {acc[30:0], 1'b0} + {28'd0, dig};
          hsp_next = 1'b0;
        end else if (b == CH_LO_X || b == CH_UP_X) begin
          if (acc != 32'd0) begin
            tok0      = mk_tok(K_ERR, 32'd0, E_X_MISPLACE, 1'b1);
            tok_count = 2'd1;
            mode_next = close_mode;
          end else begin
            hsp_next  = 1'b0;
            mode_next = M_HEX;
          end
        end else if (b == CH_RPAREN) begin
          tok0      = mk_tok(K_INT, int_val, E_NONE, 1'b0);
          tok1      = mk_tok(K_LEND, 32'd0, E_NONE, 1'b1);
          tok_count = 2'd2;
          mode_next = close_mode;
        end else if (b == CH_COMMA || b == CH_RBRACE) begin
          tok0      = mk_tok(K_INT, int_val, E_NONE, 1'b0);
          tok_count = 2'd1;
          mode_next = M_ITEM;
        end else if (b == CH_SPACE && !hsp) begin
          hsp_next = 1'b1;
        end else begin
          tok0      = mk_tok(K_ERR, 32'd0, E_BAD_CHAR, 1'b1);
          tok_count = 2'd1;
          mode_next = close_mode;
        end
      end
      M_HEX: begin
        if (is_hex(b) && !hsp) begin
          acc_next = {acc[27:0], hdig};
        end else if (b == CH_SPACE && !hsp) begin
          hsp_next = 1'b1;
        end else if (b == CH_RPAREN) begin
          tok0      = mk_tok(K_INT, int_val, E_NONE, 1'b0);
          tok1      = mk_tok(K_LEND, 32'd0, E_NONE, 1'b1);
          tok_count = 2'd2;
          mode_next = close_mode;
        end else if (b == CH_COMMA) begin
          tok0      = mk_tok(K_INT, int_val, E_NONE, 1'b0);
          tok_count = 2'd1;
          mode_next = M_ITEM;
        end else begin
          tok0      = mk_tok(K_ERR, 32'd0, E_BAD_HEX, 1'b1);
          tok_count = 2'd1;
          mode_next = close_mode;
        end
      end
      M_CHR: begin
        if (b == CH_NUL) begin
          tok0      = mk_tok(K_ERR, 32'd0, E_EARLY_END, 1'b1);
          tok_count = 2'd1;
          mode_next = close_mode;
        end else if (b == CH_SQUOTE) begin
          tok0      = mk_tok(K_ERR, 32'd0, E_CHR_EMPTY, 1'b1);
          tok_count = 2'd1;
          mode_next = close_mode;
        end else if (b == CH_BSLASH) begin
          mode_next = M_CHR_ESC;
        end else begin
          acc_next  = {{24{b[7]}}, b};
          mode_next = M_CHR_CLOSE;
        end
      end
      M_CHR_ESC: begin
        if (b == CH_NUL) begin
          tok0      = mk_tok(K_ERR, 32'd0, E_EARLY_END, 1'b1);
          tok_count = 2'd1;
          mode_next = close_mode;
        end else begin
          acc_next  = {{24{esc[7]}}, esc};
          mode_next = M_CHR_CLOSE;
        end
      end
      M_CHR_CLOSE: begin
        if (b != CH_SQUOTE) begin
          tok0      = mk_tok(K_ERR, 32'd0, E_CHR_OPEN, 1'b1);
          tok_count = 2'd1;
          mode_next = close_mode;
        end else begin
          tok0      = mk_tok(K_CHAR, acc, E_NONE, 1'b0);
          tok_count = 2'd1;
          mode_next = M_AFTER;
        end
      end
      M_AFTER: begin
        if (b == CH_NUL || b == CH_RPAREN) begin
          tok0      = mk_tok(K_LEND, 32'd0, E_NONE, 1'b1);
          tok_count = 2'd1;
          mode_next = close_mode;
        end else begin
          mode_next = M_ITEM;
        end
      end
      M_STR: begin
        if (b == CH_DQUOTE) begin
          tok0      = mk_tok(K_SEND, 32'd0, E_NONE, 1'b0);
          tok_count = 2'd1;
          mode_next = M_AFTER;
        end else if (b == CH_NUL) begin
          tok0      = mk_tok(K_ERR, 32'd0, E_EARLY_END, 1'b1);
          tok_count = 2'd1;
          mode_next = close_mode;
        end else if (slen >= MAX_STRING_CHARS) begin
          tok0      = mk_tok(K_ERR, 32'd0, E_STR_LONG, 1'b1);
          tok_count = 2'd1;
          mode_next = close_mode;
        end else if (b == CH_BSLASH) begin
          mode_next = M_STR_ESC;
        end else begin
          slen_next = slen + 10'd1;
          tok0      = mk_tok(K_SBYTE, {24'd0, b}, E_NONE, 1'b0);
          tok_count = 2'd1;
        end
      end
      M_STR_ESC: begin
        if (b == CH_NUL) begin
          tok0      = mk_tok(K_ERR, 32'd0, E_EARLY_END, 1'b1);
          tok_count = 2'd1;
          mode_next = close_mode;
        end else begin
          slen_next = slen + 10'd1;
          tok0      = mk_tok(K_SBYTE, {24'd0, esc}, E_NONE, 1'b0);
          tok_count = 2'd1;
          mode_next = M_STR;
        end
      end
      default: begin
        // discard the rest of the line
        if (b == CH_NUL) mode_next = M_SEEK;
      end
    endcase

    // Start of a list item (also reached after a lone minus)
    if (do_item) begin
      if (b == CH_NUL || b == CH_RPAREN) begin
        tok0      = mk_tok(K_LEND, 32'd0, E_NONE, 1'b1);
        tok_count = 2'd1;
        mode_next = close_mode;
      end else begin
        mode_next = M_ITEM;
        if (b == CH_SPACE || b == CH_COMMA) begin
          mode_next = M_ITEM;
        end else if (is_digit(b)) begin
          acc_next  = {28'd0, dig};
          neg_next  = 1'b0;
          hsp_next  = 1'b0;
          mode_next = M_DEC;
        end else if (b == CH_MINUS) begin
          mode_next = M_NEG;
        end else if (b == CH_SQUOTE) begin
          mode_next = M_CHR;
        end else if (b == CH_DQUOTE) begin
          slen_next = '0;
          mode_next = M_STR;
        end else begin
          tok0      = mk_tok(K_ERR, 32'd0, E_BAD_CHAR, 1'b1);
          tok_count = 2'd1;
          mode_next = close_mode;
        end
      end
    end
  end

endmodule
`default_nettype wire

FILE: design/cale_token_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cale_token_queue
// Back end: short token queue taking up to two tokens per cycle and
// presenting them one per transfer on the output stream.
// ----------------------------------------------------------------------------
module cale_token_queue
  import cale_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic [1:0] push_count,
  input  tok_t            push0,
  input  tok_t            push1,
  output logic            room,
  output logic            out_valid,
  input  wire logic       out_ready,
  output tok_t            out_tok
);

  tok_t              slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              pop;

  // Room for the worst case of two tokens from one byte
  assign room      = (count <= QCNT_W'(QDEPTH - 2));
  assign out_valid = (count != '0);
  assign out_tok   = slots[rd_ptr];
  assign pop       = out_valid && out_ready;

  // Token storage
  always_ff @(posedge clk) begin
    if (push_count != 2'd0) slots[wr_ptr] <= push0;
    if (push_count == 2'd2) slots[wr_ptr + QPTR_W'(1)] <= push1;
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QPTR_W'(push_count);
      if (pop) rd_ptr <= rd_ptr + QPTR_W'(1);
      count  <= count + QCNT_W'(push_count) - QCNT_W'(pop);
    end
  end

endmodule
`default_nettype wire

FILE: design/call_argument_literal_lexer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// call_argument_literal_lexer
// Lexes the argument list of a call command line into a token stream.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries the command line, one byte per transfer, NUL ending the
//   line. m_axis carries tokens: kind on tuser, value and error code in
//   tdata, and tlast on list end or error (downstream drops a line whose run
//   ends in an error token).
//   Tokens: a token is written into the token queue when the byte that
//   causes it is taken, and is offered on m_axis in queue order.
//   Throughput: one byte per cycle while s_axis_tready is high. The lexer
//   state update is registered; the output side drains one token per
//   cycle while m_axis_tready is high, so both tokens of a byte that makes
//   two (a number closed by ')') are sent in turn. A four-entry token queue
//   sits between the lexer and the output; s_axis_tready is high while it
//   has at least two free entries, so during a receiver stall the input side
//   keeps taking token-making bytes until it has fewer, and then backs up.
//   Reset: the lexer returns to seeking '(' and the queue empties.
// ----------------------------------------------------------------------------
module call_argument_literal_lexer
  import cale_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] line_byte
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata,   // [31:0] token_value, [35:32] error_code
  output logic [2:0]       m_axis_tuser,   // [2:0] token_kind
  output logic             m_axis_tlast    // last
);

  logic       room;
  logic       byte_fire;
  tok_t       tok0, tok1, head;
  logic [1:0] tok_count;
  logic [1:0] push_count;

  assign s_axis_tready = room;
  assign byte_fire     = s_axis_tvalid && room;
  assign push_count    = byte_fire ? tok_count : 2'd0;

  // Front: byte lexer
  cale_lexer u_lexer (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_fire),
    .line_byte  (s_axis_tdata),
    .tok0       (tok0),
    .tok1       (tok1),
    .tok_count  (tok_count)
  );

  // Back: token queue and output stream
  cale_token_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_count (push_count),
    .push0      (tok0),
    .push1      (tok1),
    .room       (room),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_tok    (head)
  );

  // Output packing
  assign m_axis_tdata = {4'd0, head.code, head.value};
  assign m_axis_tuser = head.kind;
  assign m_axis_tlast = head.last;

endmodule
`default_nettype wire
